FILE: hw/rtl/tpr_pkg.sv
// Shared types and constants for the TCP port-redirect NAT.
// Used by the interfaces, controller, datapath and top level.
package tpr_pkg;

	localparam int FLOW_AW    = 16;
	localparam int FLOW_DEPTH = 65536;
	localparam int EP_W       = 48;
	localparam int ENTRY_W    = 3 * EP_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes: host address first, route slots from REG_ROUTE0 on
	localparam logic [CFG_IDX_W-1:0] REG_HOST = 3'd0;
	localparam int REG_ROUTE0 = 1;

	localparam logic [7:0] LOOPBACK_BYTE = 8'h7f;

	typedef struct packed {
		logic        has_tcp;
		logic        dir_in;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} tuple_t;

	typedef struct packed {
		logic               load_in;
		logic               rd_en;
		logic               finish;
		logic               clr_we;
		logic [FLOW_AW-1:0] clr_addr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_full;
	} ctrl_sts_t;

endpackage

FILE: hw/rtl/tpr_ifs.sv
// Handshake channel interfaces: header tuple, result tuple, config write.
// Depends on tpr_pkg for widths.
interface tpr_tuple_if;
	logic        valid;
	logic        ready;
	logic        has_tcp;
	logic        dir_in;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	modport source (output valid, has_tcp, dir_in, source_ip, dest_ip, source_port,
		dest_port, input ready);
	modport sink (input valid, has_tcp, dir_in, source_ip, dest_ip, source_port,
		dest_port, output ready);
endinterface

interface tpr_result_if;
	logic        valid;
	logic        ready;
	logic        rewritten;
	logic        dir_out;
	logic [31:0] new_source_ip;
	logic [31:0] new_dest_ip;
	logic [15:0] new_source_port;
	logic [15:0] new_dest_port;
	modport source (output valid, rewritten, dir_out, new_source_ip, new_dest_ip,
		new_source_port, new_dest_port, input ready);
	modport sink (input valid, rewritten, dir_out, new_source_ip, new_dest_ip,
		new_source_port, new_dest_port, output ready);
endinterface

interface tpr_cfg_if
	import tpr_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hw/rtl/tpr_ctrl.sv
// Controller: flow-table clearing sweep, per-word read/resolve sequencing.
// Depends on tpr_pkg and tpr_ifs.
module tpr_ctrl
	import tpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tpr_tuple_if.sink  tuple,
	input  ctrl_sts_t  sts,
	output ctrl_cmd_t  cmd
);
	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [FLOW_AW-1:0] clr_cnt_q;
	logic               accept;
	logic               finish;

	assign finish = (state_q == ST_RES) && !sts.out_full;
	// a new word may enter in the same cycle the previous one resolves
	assign tuple.ready = (state_q == ST_IDLE) || finish;
	assign accept = tuple.valid && tuple.ready;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = accept;
		cmd.rd_en    = (state_q == ST_RD);
		cmd.finish   = finish;
		cmd.clr_we   = (state_q == ST_CLR);
		cmd.clr_addr = clr_cnt_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_cnt_q == {FLOW_AW{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (finish) begin
					state_d = accept ? ST_RD : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !tuple.ready)
		else $error("word accepted during flow table clear");
	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_full)
		else $error("result resolved into a full output register");
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RD))
		else $error("accepted word did not start a table read");
	a_read_to_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_RES))
		else $error("table read not followed by resolve");
endmodule

FILE: hw/rtl/tpr_dp.sv
// Datapath: config registers, route match, flow table, rewrite and result register.
// Depends on tpr_pkg, tpr_ifs and tpr_ram.
module tpr_dp
	import tpr_pkg::*;
#(
	parameter int ROUTE_SLOTS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tuple_t       tuple_in,
	tpr_cfg_if.sink      cfg,
	tpr_result_if.source result,
	input  ctrl_cmd_t    cmd,
	output ctrl_sts_t    sts
);
	logic [31:0]           host_q;
	logic [CFG_DATA_W-1:0] route_q [ROUTE_SLOTS];
	tuple_t                tup_q;

	logic        out_valid_q;
	logic        rewritten_q, dir_q;
	logic [31:0] sip_q, dip_q;
	logic [15:0] sp_q, dp_q;

	logic               route_hit;
	logic [31:0]        tgt_ip;
	logic [15:0]        tgt_port;
	logic               to_host, do_route, reply_check, hairpin, reply_hit;
	logic [EP_W-1:0]    peer_rd, od_rd, os_rd;
	logic [ENTRY_W-1:0] rdata, wdata, item_wdata;
	logic               we;
	logic [FLOW_AW-1:0] waddr;

	logic        r_done, r_dir;
	logic [31:0] r_sip, r_dip;
	logic [15:0] r_sp, r_dp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_q <= '0;
			for (int k = 0; k < ROUTE_SLOTS; k++) begin
				route_q[k] <= '0;
			end
		end else if (cfg.valid) begin
			if (cfg.index == REG_HOST) begin
				host_q <= cfg.data[31:0];
			end
			for (int k = 0; k < ROUTE_SLOTS; k++) begin
				if (cfg.index == CFG_IDX_W'(REG_ROUTE0 + k)) begin
					route_q[k] <= cfg.data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tup_q <= tuple_in;
		end
	end

	// lowest slot wins; match port 0 marks an unused slot
	always_comb begin
		route_hit = 1'b0;
		tgt_ip    = '0;
		tgt_port  = '0;
		for (int k = 0; k < ROUTE_SLOTS; k++) begin
			if (!route_hit && route_q[k][63:48] != 16'd0 &&
					route_q[k][63:48] == tup_q.dest_port) begin
				route_hit = 1'b1;
				tgt_ip    = route_q[k][47:16];
				tgt_port  = route_q[k][15:0];
			end
		end
	end

	tpr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(FLOW_DEPTH)
	) u_flow (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(tup_q.dest_port),
		.rdata(rdata)
	);

	assign peer_rd = rdata[3*EP_W-1:2*EP_W];
	assign od_rd   = rdata[2*EP_W-1:EP_W];
	assign os_rd   = rdata[EP_W-1:0];

	assign to_host     = (tup_q.dest_ip == host_q);
	assign do_route    = tup_q.has_tcp && !tup_q.dir_in && to_host && route_hit;
	assign reply_check = tup_q.has_tcp && (tup_q.dir_in || (to_host && !route_hit));
	assign hairpin     = (tgt_ip[7:0] == LOOPBACK_BYTE) || (tgt_ip == tup_q.source_ip);
	assign reply_hit   = reply_check &&
		(peer_rd == {tup_q.source_ip, tup_q.source_port});

	always_comb begin
		r_done = 1'b0;
		r_dir  = tup_q.dir_in;
		r_sip  = tup_q.source_ip;
		r_dip  = tup_q.dest_ip;
		r_sp   = tup_q.source_port;
		r_dp   = tup_q.dest_port;
		if (do_route) begin
			r_done = 1'b1;
			r_dp   = tgt_port;
			if (hairpin) begin
				r_dip = tup_q.source_ip;
				r_sip = host_q;
				r_dir = 1'b1;
			end else begin
				r_dip = tgt_ip;
			end
		end else if (reply_hit) begin
			r_done = 1'b1;
			r_dir  = 1'b1;
			r_sip  = od_rd[47:16];
			r_sp   = od_rd[15:0];
			r_dip  = os_rd[47:16];
			r_dp   = os_rd[15:0];
		end
	end

	// entry: {peer, original dest, original source}, keyed by source port
	assign item_wdata = {r_dip, r_dp, tup_q.dest_ip, tup_q.dest_port,
		tup_q.source_ip, tup_q.source_port};
	assign we    = cmd.clr_we || (cmd.finish && do_route);
	assign waddr = cmd.clr_we ? cmd.clr_addr : tup_q.source_port;
	assign wdata = cmd.clr_we ? '0 : item_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rewritten_q <= r_done;
			dir_q       <= r_dir;
			sip_q       <= r_sip;
			dip_q       <= r_dip;
			sp_q        <= r_sp;
			dp_q        <= r_dp;
		end
	end

	assign sts.out_full           = out_valid_q;
	assign result.valid           = out_valid_q;
	assign result.rewritten       = rewritten_q;
	assign result.dir_out         = dir_q;
	assign result.new_source_ip   = sip_q;
	assign result.new_dest_ip     = dip_q;
	assign result.new_source_port = sp_q;
	assign result.new_dest_port   = dp_q;

	a_route_excludes_reply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(do_route && reply_check))
		else $error("route hit and reply lookup both active");
	a_no_write_while_idle_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !we)
		else $error("flow table written during read cycle");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> out_valid_q)
		else $error("pending result word dropped");
endmodule

FILE: hw/rtl/tcp_port_redirect_nat.sv
// TCP port-redirect NAT: rewrites one TCP header tuple per word. After reset the
// 65536-entry flow table is swept to zero, one entry per cycle, and no header
// word is taken until the sweep ends (config writes are taken throughout).
// Each header word then goes through a flow-table read at the destination
// port, then a resolve step that matches, rewrites and records the flow at the
// source port; the next word is accepted in that resolve cycle while the output
// register is free. A result left waiting in the output register holds the
// word behind it in the resolve cycle. Route slots above ROUTE_SLOTS are not
// stored. Depends on tpr_pkg, tpr_ifs, tpr_ram, tpr_ctrl and tpr_dp.
module tcp_port_redirect_nat
	import tpr_pkg::*;
#(
	parameter int ROUTE_SLOTS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	tpr_tuple_if.sink    tuple,
	tpr_result_if.source result,
	tpr_cfg_if.sink      cfg
);
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	tuple_t    tuple_in;

	assign tuple_in = '{
		has_tcp:     tuple.has_tcp,
		dir_in:      tuple.dir_in,
		source_ip:   tuple.source_ip,
		dest_ip:     tuple.dest_ip,
		source_port: tuple.source_port,
		dest_port:   tuple.dest_port
	};

	tpr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.tuple (tuple),
		.sts   (sts),
		.cmd   (cmd)
	);

	tpr_dp #(
		.ROUTE_SLOTS(ROUTE_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.tuple_in(tuple_in),
		.cfg     (cfg),
		.result  (result),
		.cmd     (cmd),
		.sts     (sts)
	);
endmodule
